FILE: hdl/tecs_pkg.sv
// ----------------------------------------------------------------------------
// tecs_pkg
// Shared types and constants for the tiny eight-bit processor step core.
// ----------------------------------------------------------------------------
package tecs_pkg;

  // fixed geometry
  localparam int unsigned RegCount    = 4;
  localparam int unsigned DataDepth   = 8;
  localparam int unsigned ProgramSize = 128;  // 1 .. 256

  localparam int unsigned RegAddrW  = $clog2(RegCount);
  localparam int unsigned DataAddrW = $clog2(DataDepth);

  localparam logic [RegAddrW-1:0] AccIdx = '0;  // r0, the accumulator

  // instruction class, bits 7:5
  typedef enum logic [2:0] {
    CLS_XFER  = 3'b000,
    CLS_ARITH = 3'b001,
    CLS_SHIFT = 3'b010,
    CLS_CMP   = 3'b011,
    CLS_PORT  = 3'b100,
    CLS_JZ    = 3'b101,
    CLS_JMP   = 3'b110,
    CLS_NOP   = 3'b111
  } cls_e;

  // data transfer kind, bits 4:3
  typedef enum logic [1:0] {
    XF_LOAD  = 2'b00,
    XF_STORE = 2'b01,
    XF_MOVE  = 2'b10,
    XF_IMM   = 2'b11
  } xfer_e;

  // read addresses from execute to the state block
  typedef struct packed {
    logic [RegAddrW-1:0]  ra;
    logic [RegAddrW-1:0]  rb;
    logic [DataAddrW-1:0] mem;
  } rd_addr_t;

  // current state seen by execute
  typedef struct packed {
    logic [7:0] pc;
    logic       zero;
    logic [7:0] r0;
    logic [7:0] ra;
    logic [7:0] rb;
    logic [7:0] mem;
  } st_view_t;

  // state update from execute
  typedef struct packed {
    logic                 commit;
    logic [7:0]           pc;
    logic                 zero;
    logic                 reg_we;
    logic [RegAddrW-1:0]  reg_waddr;
    logic [7:0]           reg_wdata;
    logic                 mem_we;
    logic [DataAddrW-1:0] mem_waddr;
    logic [7:0]           mem_wdata;
  } wr_t;

  // one result item
  typedef struct packed {
    logic [7:0] next_pc;
    logic       halted;
    logic       zero_flag;
    logic       out_valid;
    logic [2:0] out_port;
    logic [7:0] out_data;
  } res_t;

  // program counter beyond the program
  function automatic logic is_halted(input logic [7:0] pc);
    return {1'b0, pc} >= 9'(ProgramSize);
  endfunction

endpackage

FILE: hdl/tecs_state.sv
// ----------------------------------------------------------------------------
// tecs_state
// Architectural state: program counter, zero flag, register file and data
// store, with combinational read ports and one write port each.
// ----------------------------------------------------------------------------
module tecs_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tecs_pkg::rd_addr_t  rd_addr_i,
  input  tecs_pkg::wr_t       wr_i,
  output tecs_pkg::st_view_t  st_o
);

  logic [7:0] pc_q;
  logic       zero_q;
  logic [7:0] regs_q [tecs_pkg::RegCount];
  logic [7:0] dmem_q [tecs_pkg::DataDepth];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      zero_q <= 1'b0;
    end else if (wr_i.commit) begin
      pc_q   <= wr_i.pc;
      zero_q <= wr_i.zero;
    end
  end

  // register file, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tecs_pkg::RegCount; i++) begin
        regs_q[i] <= '0;
      end
    end else if (wr_i.reg_we) begin
      regs_q[wr_i.reg_waddr] <= wr_i.reg_wdata;
    end
  end

  // data store, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tecs_pkg::DataDepth; i++) begin
        dmem_q[i] <= '0;
      end
    end else if (wr_i.mem_we) begin
      dmem_q[wr_i.mem_waddr] <= wr_i.mem_wdata;
    end
  end

  // read ports
  always_comb begin
    st_o.pc   = pc_q;
    st_o.zero = zero_q;
    st_o.r0   = regs_q[tecs_pkg::AccIdx];
    st_o.ra   = regs_q[rd_addr_i.ra];
    st_o.rb   = regs_q[rd_addr_i.rb];
    st_o.mem  = dmem_q[rd_addr_i.mem];
  end

endmodule

FILE: hdl/tecs_exec.sv
// ----------------------------------------------------------------------------
// tecs_exec
// Single-pass instruction decode and execute: read addresses, state update
// and the result item for the instruction at the current program counter.
// ----------------------------------------------------------------------------
module tecs_exec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          instr_i,
  input  logic                accept_i,
  input  tecs_pkg::st_view_t  st_i,
  output tecs_pkg::rd_addr_t  rd_addr_o,
  output tecs_pkg::wr_t       wr_o,
  output tecs_pkg::res_t      res_o
);

  tecs_pkg::cls_e  cls;
  tecs_pkg::xfer_e kind;
  logic            halted_now;
  logic [7:0]      new_r0;
  logic [7:0]      alu_res;

  assign cls        = tecs_pkg::cls_e'(instr_i[7:5]);
  assign kind       = tecs_pkg::xfer_e'(instr_i[4:3]);
  assign halted_now = tecs_pkg::is_halted(st_i.pc);

  // read addresses: the move source shares the second port
  always_comb begin
    rd_addr_o.ra  = instr_i[4:3];
    rd_addr_o.rb  = (cls == tecs_pkg::CLS_XFER) ? instr_i[2:1] : instr_i[1:0];
    rd_addr_o.mem = instr_i[2:0];
  end

  // decode and execute
  always_comb begin
    new_r0  = st_i.r0;
    alu_res = instr_i[2] ? (st_i.ra - st_i.rb) : (st_i.ra + st_i.rb);

    wr_o.commit    = accept_i && !halted_now;
    wr_o.pc        = st_i.pc + 8'd1;
    wr_o.zero      = st_i.zero;
    wr_o.reg_we    = 1'b0;
    wr_o.reg_waddr = instr_i[4:3];
    wr_o.reg_wdata = alu_res;
    wr_o.mem_we    = 1'b0;
    wr_o.mem_waddr = instr_i[2:0];
    wr_o.mem_wdata = st_i.r0;

    res_o.out_valid = 1'b0;
    res_o.out_port  = '0;
    res_o.out_data  = '0;

    unique case (cls)
      tecs_pkg::CLS_XFER: begin
        wr_o.reg_waddr = tecs_pkg::AccIdx;
        unique case (kind)
          tecs_pkg::XF_LOAD: begin
            wr_o.reg_we    = 1'b1;
            wr_o.reg_wdata = st_i.mem;
            new_r0         = st_i.mem;
          end
          tecs_pkg::XF_STORE: begin
            wr_o.mem_we = 1'b1;
          end
          tecs_pkg::XF_MOVE: begin
            wr_o.reg_we    = 1'b1;
            wr_o.reg_waddr = instr_i[1:0];
            wr_o.reg_wdata = st_i.rb;
            if (instr_i[1:0] == tecs_pkg::AccIdx) begin
              new_r0 = st_i.rb;
            end
          end
          tecs_pkg::XF_IMM: begin
            wr_o.reg_we    = 1'b1;
            wr_o.reg_wdata = {5'd0, instr_i[2:0]};
            new_r0         = {5'd0, instr_i[2:0]};
          end
          default: ;
        endcase
        wr_o.zero = (new_r0 == 8'd0);
      end
      tecs_pkg::CLS_ARITH: begin
        wr_o.reg_we = 1'b1;
        wr_o.zero   = (alu_res == 8'd0);
      end
      tecs_pkg::CLS_SHIFT: begin
        wr_o.reg_we    = 1'b1;
        wr_o.reg_wdata = instr_i[2] ? {4'd0, st_i.ra[7:4]} : {st_i.ra[3:0], 4'd0};
      end
      tecs_pkg::CLS_CMP: begin
        wr_o.zero = (st_i.ra == st_i.rb);
      end
      tecs_pkg::CLS_PORT: begin
        if (!instr_i[3] && !halted_now) begin
          res_o.out_valid = 1'b1;
          res_o.out_port  = instr_i[2:0];
          res_o.out_data  = st_i.rb;
        end
      end
      tecs_pkg::CLS_JZ: begin
        if (st_i.zero) begin
          wr_o.pc = st_i.rb;
        end
      end
      tecs_pkg::CLS_JMP: begin
        wr_o.pc = st_i.rb;
      end
      tecs_pkg::CLS_NOP: ;
      default: ;
    endcase

    // writes only take effect on a committed step
    wr_o.reg_we = wr_o.reg_we && wr_o.commit;
    wr_o.mem_we = wr_o.mem_we && wr_o.commit;

    res_o.next_pc   = halted_now ? st_i.pc : wr_o.pc;
    res_o.halted    = tecs_pkg::is_halted(res_o.next_pc);
    res_o.zero_flag = halted_now ? st_i.zero : wr_o.zero;
  end

  // a halted core never writes state
  a_no_write_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_now |-> !wr_o.commit && !wr_o.reg_we && !wr_o.mem_we)
    else $error("state write while halted");

  // a committed non-jump step advances the counter by one
  a_pc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_o.commit && cls != tecs_pkg::CLS_JZ && cls != tecs_pkg::CLS_JMP)
      |-> wr_o.pc == st_i.pc + 8'd1)
    else $error("program counter did not increment");

endmodule

FILE: hdl/tecs_out_buf.sv
// ----------------------------------------------------------------------------
// tecs_out_buf
// Two-entry result buffer: an output register plus a skid entry, so a new
// item is taken while a finished result still waits downstream.
// ----------------------------------------------------------------------------
module tecs_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tecs_pkg::res_t  push_data_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            ready_i,
  output tecs_pkg::res_t  data_o
);

  logic           main_valid_q, main_valid_d;
  logic           skid_valid_q, skid_valid_d;
  tecs_pkg::res_t main_q, main_d;
  tecs_pkg::res_t skid_q, skid_d;
  logic           pop;

  assign pop     = main_valid_q && ready_i;
  assign full_o  = skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  // next state of both entries
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    priority if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  // skid entry only fills behind a full output register
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry valid with empty output register");

  // no push is taken while the skid entry is occupied
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("push into full result buffer");

  // a stalled output with a push lands in the skid entry
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && main_valid_q && !ready_i) |=> skid_valid_q)
    else $error("result lost on stalled output");

endmodule

FILE: hdl/tiny_eight_bit_cpu_step_core.sv
// ----------------------------------------------------------------------------
// tiny_eight_bit_cpu_step_core
// Results are registered in the result buffer. Throughput: one item per cycle
// while the buffer has room; decode and execute is a single pass from the
// state registers into the two-entry result buffer.
// Input stalls only when both result buffer entries are occupied.
// Reset clears counter, zero flag, register file, data store and buffer.
// ----------------------------------------------------------------------------
module tiny_eight_bit_cpu_step_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] instr_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] next_pc_o,
  output logic       halted_o,
  output logic       zero_flag_o,
  output logic       out_valid_o,
  output logic [2:0] out_port_o,
  output logic [7:0] out_data_o
);

  tecs_pkg::rd_addr_t rd_addr;
  tecs_pkg::st_view_t st_view;
  tecs_pkg::wr_t      wr;
  tecs_pkg::res_t     exec_res;
  tecs_pkg::res_t     res;
  logic               buf_full;
  logic               accept;

  assign in_ready_o = !buf_full;
  assign accept     = in_valid_i && in_ready_o;

  // architectural state
  tecs_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .st_o      (st_view)
  );

  // decode and execute
  tecs_exec u_exec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .instr_i   (instr_i),
    .accept_i  (accept),
    .st_i      (st_view),
    .rd_addr_o (rd_addr),
    .wr_o      (wr),
    .res_o     (exec_res)
  );

  // result buffer
  tecs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (exec_res),
    .full_o      (buf_full),
    .valid_o     (res_valid_o),
    .ready_i     (res_ready_i),
    .data_o      (res)
  );

  assign next_pc_o   = res.next_pc;
  assign halted_o    = res.halted;
  assign zero_flag_o = res.zero_flag;
  assign out_valid_o = res.out_valid;
  assign out_port_o  = res.out_port;
  assign out_data_o  = res.out_data;

  // a port field is only nonzero on a port output result
  a_port_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !out_valid_o) |-> (out_port_o == 3'd0 && out_data_o == 8'd0))
    else $error("port fields set without port output");

  // an item accepted while halted leaves the counter alone
  a_halt_holds_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && tecs_pkg::is_halted(st_view.pc)) |=> $stable(st_view.pc))
    else $error("program counter moved while halted");

  // the halted flag of the result tracks its counter
  a_halt_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (halted_o == tecs_pkg::is_halted(next_pc_o)))
    else $error("halted flag inconsistent with next counter");

endmodule
